/* design/rgb_to_hue_assert.svh */
// Assertion macros shared by the hue pipeline.
// Define ASSERT_OFF to compile the checks out.
`ifndef RGB_TO_HUE_ASSERT_SVH
`define RGB_TO_HUE_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define RTH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hue: next-cycle check failed");

`else

`define RTH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/rth_pkg.sv */
`timescale 1ns / 1ps

package rth_pkg;

   // Width of one color component.
   localparam int COMP_BITS = 8;
   // Divisor 6*d reaches 1530, so it and the partial remainder need 11 bits.
   localparam int DEN_BITS = 11;
   // Width of the hue field on the result channel.
   localparam int HUE_FIELD_BITS = 16;
   // Divisor used for a gray pixel, so the quotient comes out zero.
   localparam logic [DEN_BITS-1:0] GRAY_DEN = DEN_BITS'(1);

   // Offset added to the component difference, in units of 2*d.
   typedef enum logic [1:0] {
      OFS_ZERO = 2'd0,
      OFS_2D   = 2'd1,
      OFS_4D   = 2'd2,
      OFS_6D   = 2'd3
   } offset_type;

   // Payload of one divider stage.
   typedef struct packed {
      logic                gray;
      logic [DEN_BITS-1:0] den;
      logic [DEN_BITS-1:0] rem;
   } div_data_type;

endpackage

/* design/rth_req_if.sv */
`timescale 1ns / 1ps

interface rth_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* design/rth_rsp_if.sv */
`timescale 1ns / 1ps

interface rth_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] hue;
   logic        achromatic;

   modport source (output valid, output hue, output achromatic, input ready);
   modport sink (input valid, input hue, input achromatic, output ready);
endinterface

/* design/rth_div_step.sv */
`timescale 1ns / 1ps

// One restoring division step: shifts the remainder, subtracts the divisor
// when it fits and appends one quotient bit.
module rth_div_step import rth_pkg::*; #(
   parameter int QUO_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  div_data_type        in_data,
   input  logic [QUO_BITS-1:0] in_quo,
   output logic                out_valid,
   output div_data_type        out_data,
   output logic [QUO_BITS-1:0] out_quo
);

   logic                valid_ff;
   div_data_type        data_ff;
   logic [QUO_BITS-1:0] quo_ff;

   logic [DEN_BITS:0]   rem_dbl;
   logic [DEN_BITS:0]   rem_sub;
   logic                take;
   div_data_type        data_in;
   logic [QUO_BITS-1:0] quo_in;

   // Shift in a zero, then subtract the divisor if the result allows it.
   always_comb begin
      rem_dbl = {in_data.rem, 1'b0};
      rem_sub = rem_dbl - {1'b0, in_data.den};
      take    = (rem_dbl >= {1'b0, in_data.den});
      data_in      = in_data;
      data_in.rem  = take ? rem_sub[DEN_BITS-1:0] : rem_dbl[DEN_BITS-1:0];
      quo_in       = {in_quo[QUO_BITS-2:0], take};
   end

   // Valid bit follows the pipeline enable and clears on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload registers move with the pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         quo_ff  <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_quo   = quo_ff;

endmodule

/* design/rgb_to_hue.sv */
`timescale 1ns / 1ps

// HSL hue of an 8-bit RGB pixel, as an unsigned fraction of a full turn.
//
// Input channel req_ch carries red, green and blue; result channel rsp_ch
// carries hue (HUE_BITS fraction bits, presented in the 16-bit field) and
// achromatic, which is set for a gray pixel whose hue is then zero.
// Each channel moves one transfer when valid and ready are both high.
//
// An input transfer reaches the result register through three stages that find
// max, min, d and the numerator, then one stage per quotient bit dividing exactly by
// 6*d. Throughput is one pixel per cycle while the receiver does not stall.
//
// The whole pipeline advances together. When the receiver holds ready low
// with a result waiting, every stage holds and req_ch.ready drops, so
// nothing is lost or repeated. Reset (synchronous) clears all valid bits;
// the payload registers are not reset.
module rgb_to_hue import rth_pkg::*; #(
   parameter int HUE_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   rth_req_if.sink   req_ch,
   rth_rsp_if.source rsp_ch
);

   `include "rgb_to_hue_assert.svh"

   logic advance;

   // Stage 1 registers: extremes, offset code and component difference.
   logic                 s1_valid_ff;
   logic [COMP_BITS-1:0] s1_max_ff;
   logic [COMP_BITS-1:0] s1_min_ff;
   offset_type           s1_ofs_ff;
   logic signed [COMP_BITS:0] s1_diff_ff;

   logic [COMP_BITS-1:0] s1_max_in;
   logic [COMP_BITS-1:0] s1_min_in;
   offset_type           s1_ofs_in;
   logic signed [COMP_BITS:0] s1_diff_in;

   // Stage 2 registers: spread d and the gray flag.
   logic                 s2_valid_ff;
   logic [COMP_BITS-1:0] s2_d_ff;
   logic                 s2_gray_ff;
   offset_type           s2_ofs_ff;
   logic signed [COMP_BITS:0] s2_diff_ff;

   // Stage 3 registers: numerator and divisor entering the divider.
   logic          s3_valid_ff;
   div_data_type  s3_data_ff;
   div_data_type  s3_data_in;
   logic [COMP_BITS+1:0] half_ofs;

   // Divider chain; index 0 is stage 3, index HUE_BITS the output register.
   logic                stage_valid [HUE_BITS+1];
   div_data_type        stage_data  [HUE_BITS+1];
   logic [HUE_BITS-1:0] stage_quo   [HUE_BITS+1];

   // All stages move when the output is empty or being taken.
   assign advance      = !stage_valid[HUE_BITS] || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Stage 1: red wins ties, then green, then blue.
   always_comb begin
      priority if (req_ch.red >= req_ch.green && req_ch.red >= req_ch.blue) begin
         s1_max_in  = req_ch.red;
         s1_ofs_in  = (req_ch.green >= req_ch.blue) ? OFS_ZERO : OFS_6D;
         s1_diff_in = $signed({1'b0, req_ch.green}) - $signed({1'b0, req_ch.blue});
      end else if (req_ch.green >= req_ch.blue) begin
         s1_max_in  = req_ch.green;
         s1_ofs_in  = OFS_2D;
         s1_diff_in = $signed({1'b0, req_ch.blue}) - $signed({1'b0, req_ch.red});
      end else begin
         s1_max_in  = req_ch.blue;
         s1_ofs_in  = OFS_4D;
         s1_diff_in = $signed({1'b0, req_ch.red}) - $signed({1'b0, req_ch.green});
      end
      if (req_ch.red <= req_ch.green && req_ch.red <= req_ch.blue) begin
         s1_min_in = req_ch.red;
      end else if (req_ch.green <= req_ch.blue) begin
         s1_min_in = req_ch.green;
      end else begin
         s1_min_in = req_ch.blue;
      end
   end

   // Stage 3: numerator is offset*d plus the difference, divisor is 6*d.
   always_comb begin
      unique case (s2_ofs_ff)
         OFS_ZERO: half_ofs = '0;
         OFS_2D:   half_ofs = {2'b00, s2_d_ff};
         OFS_4D:   half_ofs = {1'b0, s2_d_ff, 1'b0};
         OFS_6D:   half_ofs = {1'b0, s2_d_ff, 1'b0} + {2'b00, s2_d_ff};
         default:  half_ofs = '0;
      endcase
      s3_data_in.gray = s2_gray_ff;
      // The true sum always lies in 0 .. 6*d-1, so 11-bit wraparound is exact.
      s3_data_in.rem  = {half_ofs, 1'b0} + {{(DEN_BITS-COMP_BITS-1){s2_diff_ff[COMP_BITS]}},
                                            s2_diff_ff};
      s3_data_in.den  = s2_gray_ff ? GRAY_DEN
                                   : {1'b0, s2_d_ff, 2'b00} + {2'b00, s2_d_ff, 1'b0};
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload of the front stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_max_ff  <= s1_max_in;
         s1_min_ff  <= s1_min_in;
         s1_ofs_ff  <= s1_ofs_in;
         s1_diff_ff <= s1_diff_in;
         s2_d_ff    <= s1_max_ff - s1_min_ff;
         s2_gray_ff <= (s1_max_ff == s1_min_ff);
         s2_ofs_ff  <= s1_ofs_ff;
         s2_diff_ff <= s1_diff_ff;
         s3_data_ff <= s3_data_in;
      end
   end

   assign stage_valid[0] = s3_valid_ff;
   assign stage_data[0]  = s3_data_ff;
   assign stage_quo[0]   = '0;

   // One quotient bit per stage.
   for (genvar i = 0; i < HUE_BITS; i++) begin : g_div
      rth_div_step #(
         .QUO_BITS (HUE_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[i]),
         .in_data   (stage_data[i]),
         .in_quo    (stage_quo[i]),
         .out_valid (stage_valid[i+1]),
         .out_data  (stage_data[i+1]),
         .out_quo   (stage_quo[i+1])
      );
   end

   // Result channel, with the quotient fitted to the 16-bit field.
   assign rsp_ch.valid      = stage_valid[HUE_BITS];
   assign rsp_ch.achromatic = stage_data[HUE_BITS].gray;

   if (HUE_BITS >= HUE_FIELD_BITS) begin : g_hue_trunc
      assign rsp_ch.hue = stage_quo[HUE_BITS][HUE_FIELD_BITS-1:0];
   end else begin : g_hue_ext
      assign rsp_ch.hue = {{(HUE_FIELD_BITS-HUE_BITS){1'b0}}, stage_quo[HUE_BITS]};
   end

   // The divider starts with a numerator below its divisor and keeps it so.
   `RTH_ASSERT_IMPLY(a_div_entry, clock, reset, stage_valid[0], stage_data[0].rem < stage_data[0].den)
   `RTH_ASSERT_IMPLY(a_div_exit, clock, reset, stage_valid[HUE_BITS], stage_data[HUE_BITS].rem < stage_data[HUE_BITS].den)
   // An input transfer always lands in the first stage.
   `RTH_ASSERT_NEXT(a_front_fill, clock, reset, req_ch.valid && req_ch.ready, s1_valid_ff)
   // A gray pixel leaves with a zero hue.
   `RTH_ASSERT_IMPLY(a_gray_hue, clock, reset, rsp_ch.valid && rsp_ch.achromatic, rsp_ch.hue == '0)

endmodule
